>>> hw/rtl/iirdf2_pkg.sv
`default_nettype none

package iirdf2_pkg;

  // Filter order and fixed-point formats.
  localparam int ORDER     = 3;
  localparam int TAPS_MAX  = 3;
  localparam int COEF_W    = 20;
  localparam int SAMPLE_W  = 16;
  localparam int STATE_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = COEF_W + STATE_W;
  localparam int ACC_W     = 56;
  localparam int RND_W     = ACC_W - FRAC_BITS;
  localparam int NUM_COEF  = 7;
  localparam int CFG_IDX_W = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A3 = 3'd6;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 20'sh10000;

  // Sequencer program.
  localparam int STEP_W    = 4;
  localparam int PROG_LEN  = 9;
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

  typedef enum logic [2:0] {
    C_B0 = 3'd0,
    C_B1 = 3'd1,
    C_B2 = 3'd2,
    C_B3 = 3'd3,
    C_A1 = 3'd4,
    C_A2 = 3'd5,
    C_A3 = 3'd6
  } coef_sel_t;

  typedef enum logic [1:0] {
    OP_D0 = 2'd0,
    OP_D1 = 2'd1,
    OP_D2 = 2'd2,
    OP_W  = 2'd3
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACCW_NONE   = 2'd0,
    ACCW_LOAD_X = 2'd1,
    ACCW_SUB    = 2'd2
  } accw_op_t;

  typedef enum logic [1:0] {
    ACCY_NONE = 2'd0,
    ACCY_LOAD = 2'd1,
    ACCY_ADD  = 2'd2
  } accy_op_t;

  typedef enum logic [1:0] {
    JMP_NONE     = 2'd0,
    JMP_NO_INPUT = 2'd1,
    JMP_OUT_BUSY = 2'd2
  } jmp_t;

  typedef struct packed {
    coef_sel_t         coef;
    opnd_sel_t         opnd;
    accw_op_t          accw;
    accy_op_t          accy;
    logic              w_ld;
    logic              out_ld;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  // The multiplier issues a product every step; the accumulators take it
  // one step later. Feedback taps go to acc_w, feedforward taps to acc_y.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '{coef: C_B0, opnd: OP_D0, accw: ACCW_NONE, accy: ACCY_NONE,
          w_ld: 1'b0, out_ld: 1'b0, jmp: JMP_NONE, target: STEP_IDLE,
          last: 1'b0};
    unique case (step)
      4'd0: begin
        u.coef = C_A1; u.opnd = OP_D0; u.accw = ACCW_LOAD_X;
        u.jmp = JMP_NO_INPUT; u.target = STEP_IDLE;
      end
      4'd1: begin
        u.coef = C_A2; u.opnd = OP_D1; u.accw = ACCW_SUB;
      end
      4'd2: begin
        u.coef = C_A3; u.opnd = OP_D2; u.accw = ACCW_SUB;
      end
      4'd3: begin
        u.coef = C_B1; u.opnd = OP_D0; u.accw = ACCW_SUB;
      end
      4'd4: begin
        u.coef = C_B2; u.opnd = OP_D1; u.accy = ACCY_LOAD; u.w_ld = 1'b1;
      end
      4'd5: begin
        u.coef = C_B3; u.opnd = OP_D2; u.accy = ACCY_ADD;
      end
      4'd6: begin
        u.coef = C_B0; u.opnd = OP_W; u.accy = ACCY_ADD;
      end
      4'd7: begin
        u.accy = ACCY_ADD;
      end
      4'd8: begin
        u.out_ld = 1'b1; u.jmp = JMP_OUT_BUSY; u.target = STEP_LAST;
        u.last = 1'b1;
      end
      default: begin
        u.last = 1'b1;
      end
    endcase
    return u;
  endfunction

  // Tap number of a coefficient, zero for b0.
  function automatic logic [1:0] coef_tap(input coef_sel_t c);
    logic [1:0] t;
    case (c)
      C_B1, C_A1: t = 2'd1;
      C_B2, C_A2: t = 2'd2;
      C_B3, C_A3: t = 2'd3;
      default:    t = 2'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [RND_W-1:0] v
  );
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    logic signed [STATE_W-1:0] r;
    hi = {{(RND_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    lo = {{(RND_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
    if (v > hi) begin
      r = hi[STATE_W-1:0];
    end else if (v < lo) begin
      r = lo[STATE_W-1:0];
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [RND_W-1:0] v
  );
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] r;
    hi = {{(RND_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    lo = {{(RND_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
    if (v > hi) begin
      r = hi[SAMPLE_W-1:0];
    end else if (v < lo) begin
      r = lo[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Round half up and drop the fraction bits.
  function automatic logic signed [RND_W-1:0] round_acc(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] s;
    s = v + {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    return s[ACC_W-1:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/iir_direct_form_two.sv
`default_nettype none
// A result beat is offered once the program has passed its final step.
// The block takes a new sample only when its program is back in the idle step;
// the nine-step program drives one shared 20x32 multiplier and two accumulators.
// A stalled result holds the program in its final step, so no new sample is taken.
// Reset (synchronous, rst_n low) zeroes the delay line, sets b0 to 1.0 and all
// other coefficients to 0, and returns the sequencer to its idle step.
module iir_direct_form_two (
  input  wire                                            clk,
  input  wire                                            rst_n,
  // Input sample channel.
  input  wire                                            in_valid,
  output logic                                           in_stall,
  input  wire  signed [iirdf2_pkg::SAMPLE_W-1:0]         in_sample_in,
  // Result channel.
  output logic                                           out_valid,
  input  wire                                            out_stall,
  output logic signed [iirdf2_pkg::SAMPLE_W-1:0]         out_sample_out,
  // Coefficient write port.
  input  wire                                            cfg_wr_en,
  input  wire         [iirdf2_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  signed [iirdf2_pkg::COEF_W-1:0]           cfg_data
);

  // Coefficient registers, indexed in register order: b0..b3, a1..a3.
  logic signed [iirdf2_pkg::COEF_W-1:0]   coef_r [iirdf2_pkg::NUM_COEF];

  // Delay line: entry k holds w[n-1-k].
  logic signed [iirdf2_pkg::STATE_W-1:0]  delay_r [iirdf2_pkg::TAPS_MAX];

  // Sequencer.
  logic [iirdf2_pkg::STEP_W-1:0]          step_r;
  logic [iirdf2_pkg::STEP_W-1:0]          step_nxt;
  iirdf2_pkg::ucode_t                     uc;
  logic                                   hold;
  logic                                   done;

  // Datapath.
  logic signed [iirdf2_pkg::COEF_W-1:0]   coef_mux;
  logic signed [iirdf2_pkg::STATE_W-1:0]  opnd_mux;
  logic signed [iirdf2_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [iirdf2_pkg::PROD_W-1:0]   prod_r;
  logic signed [iirdf2_pkg::ACC_W-1:0]    prod_ext;
  logic signed [iirdf2_pkg::ACC_W-1:0]    acc_w_r;
  logic signed [iirdf2_pkg::ACC_W-1:0]    acc_y_r;
  logic signed [iirdf2_pkg::STATE_W-1:0]  w_r;
  logic signed [iirdf2_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                   out_valid_r;
  logic                                   in_accept;
  logic                                   out_fire;

  // The microcode word for the current step. A step whose jump condition
  // holds repeats (jumps to its target) and performs none of its actions.
  assign uc = iirdf2_pkg::ucode_rom(step_r);

  always_comb begin
    case (uc.jmp)
      iirdf2_pkg::JMP_NO_INPUT: hold = !in_valid;
      iirdf2_pkg::JMP_OUT_BUSY: hold = out_valid_r && out_stall;
      default:                  hold = 1'b0;
    endcase
  end

  assign done = !hold;

  always_comb begin
    if (hold) begin
      step_nxt = uc.target;
    end else if (uc.last) begin
      step_nxt = iirdf2_pkg::STEP_IDLE;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= iirdf2_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // The block takes a new sample only in the idle step.
  assign in_stall  = (step_r != iirdf2_pkg::STEP_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Coefficient writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iirdf2_pkg::NUM_COEF; i++) begin
        coef_r[i] <= (i == iirdf2_pkg::REG_COEF_B0) ? iirdf2_pkg::COEF_ONE : '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        iirdf2_pkg::REG_COEF_B0, iirdf2_pkg::REG_COEF_B1,
        iirdf2_pkg::REG_COEF_B2, iirdf2_pkg::REG_COEF_B3,
        iirdf2_pkg::REG_COEF_A1, iirdf2_pkg::REG_COEF_A2,
        iirdf2_pkg::REG_COEF_A3: begin
          coef_r[cfg_index] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Operand selection. Taps above the filter order contribute nothing.
  always_comb begin
    if (32'(iirdf2_pkg::coef_tap(uc.coef)) <= iirdf2_pkg::ORDER) begin
      coef_mux = coef_r[uc.coef];
    end else begin
      coef_mux = '0;
    end
  end

  always_comb begin
    case (uc.opnd)
      iirdf2_pkg::OP_D0: opnd_mux = delay_r[0];
      iirdf2_pkg::OP_D1: opnd_mux = delay_r[1];
      iirdf2_pkg::OP_D2: opnd_mux = delay_r[2];
      default:           opnd_mux = w_r;
    endcase
  end

  // The product is registered; it reaches an accumulator one step later.
  assign prod_nxt = coef_mux * opnd_mux;
  assign prod_ext = {{(iirdf2_pkg::ACC_W-iirdf2_pkg::PROD_W){prod_r[iirdf2_pkg::PROD_W-1]}},
                     prod_r};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Feedback accumulator: x scaled to Q.16 minus the a-tap products.
  always_ff @(posedge clk) begin
    if (done) begin
      case (uc.accw)
        iirdf2_pkg::ACCW_LOAD_X: begin
          acc_w_r <= {{(iirdf2_pkg::ACC_W-iirdf2_pkg::SAMPLE_W-iirdf2_pkg::FRAC_BITS)
                       {in_sample_in[iirdf2_pkg::SAMPLE_W-1]}},
                      in_sample_in, {iirdf2_pkg::FRAC_BITS{1'b0}}};
        end
        iirdf2_pkg::ACCW_SUB: begin
          acc_w_r <= acc_w_r - prod_ext;
        end
        default: begin
        end
      endcase
    end
  end

  // Feedforward accumulator: b-tap products plus b0 times w.
  always_ff @(posedge clk) begin
    if (done) begin
      case (uc.accy)
        iirdf2_pkg::ACCY_LOAD: acc_y_r <= prod_ext;
        iirdf2_pkg::ACCY_ADD:  acc_y_r <= acc_y_r + prod_ext;
        default: begin
        end
      endcase
    end
  end

  // The intermediate value, rounded and clamped to 32 bits.
  always_ff @(posedge clk) begin
    if (done && uc.w_ld) begin
      w_r <= iirdf2_pkg::sat_state(iirdf2_pkg::round_acc(acc_w_r));
    end
  end

  // Final step: load the output register and shift w into the delay line.
  assign out_fire = done && uc.out_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < iirdf2_pkg::TAPS_MAX; i++) begin
        delay_r[i] <= '0;
      end
    end else if (out_fire) begin
      for (int i = 1; i < iirdf2_pkg::TAPS_MAX; i++) begin
        if (i < iirdf2_pkg::ORDER) begin
          delay_r[i] <= delay_r[i-1];
        end
      end
      delay_r[0] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_sample_r <= iirdf2_pkg::sat_sample(iirdf2_pkg::round_acc(acc_y_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

`ifndef SYNTHESIS
  // An accepted beat starts the program at its first compute step.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> step_r == (iirdf2_pkg::STEP_IDLE + 1'b1))
    else $error("accepted beat did not start the program");

  // A result only appears out of the final step.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step_r) == iirdf2_pkg::STEP_LAST)
    else $error("result raised outside the final step");

  // The final step waits while the previous result is still held.
  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == iirdf2_pkg::STEP_LAST && out_valid_r && out_stall)
      |=> step_r == iirdf2_pkg::STEP_LAST)
    else $error("final step left while output was busy");

  // The delay line takes the intermediate value when a result is formed.
  a_delay_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> delay_r[0] == $past(w_r))
    else $error("delay line head does not hold the new intermediate value");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the third-order direct form II IIR filter.
// An in-bench model of the filter predicts each output sample as its input
// beat is accepted, and a monitor compares every accepted output beat with
// the oldest prediction. Coefficients change only while the filter is idle.
module testbench;

  typedef logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic signed [iirdf2_pkg::COEF_W-1:0]   coef_t;
  typedef logic signed [iirdf2_pkg::STATE_W-1:0]  state_t;

  // No register lives at this index, so writes to it must be dropped.
  localparam logic [iirdf2_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam coef_t COEF_MAX   = 20'sh7FFFF;
  localparam coef_t COEF_MIN   = 20'sh80000;
  localparam coef_t COEF_UNITY = 20'sh10000;

  localparam longint STATE_HI  = 64'sd2147483647;
  localparam longint STATE_LO  = -64'sd2147483648;
  localparam longint SAMPLE_HI = 64'sd32767;
  localparam longint SAMPLE_LO = -64'sd32768;

  // The filter is back in its idle step once the last output beat has been
  // taken; the settle wait keeps a margin on top of that.
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;

  logic    clk            = 1'b0;
  logic    rst_n          = 1'b0;
  logic    in_valid       = 1'b0;
  sample_t in_sample_in   = '0;
  logic    out_stall      = 1'b0;
  logic    cfg_wr_en      = 1'b0;
  logic [iirdf2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  coef_t   cfg_data       = '0;

  wire     in_stall;
  wire     out_valid;
  wire signed [iirdf2_pkg::SAMPLE_W-1:0] out_sample_out;

  iir_direct_form_two dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // The period is 4 ns.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model state: the coefficient copies and the delay line, which holds
  // w[n-1], w[n-2] and w[n-3] at indexes 0, 1 and 2. The reset values
  // match the filter after reset.
  coef_t  ff_coef [0:3] = '{COEF_UNITY, 20'sd0, 20'sd0, 20'sd0};
  coef_t  fb_coef [1:3] = '{20'sd0, 20'sd0, 20'sd0};
  state_t w_delay [0:2] = '{32'sd0, 32'sd0, 32'sd0};

  sample_t expected_samples [$];
  sample_t oldest_sample;
  int      errors        = 0;
  int      cycle_count   = 0;
  int      send_idle_pct = 21;
  int      recv_idle_pct = 51;

  // Round half up and drop the sixteen fraction bits. The arithmetic shift
  // takes the floor, which is what the filter does for negative sums.
  function automatic longint round_frac(input longint acc);
    return (acc + 64'sd32768) >>> iirdf2_pkg::FRAC_BITS;
  endfunction

  // Runs one sample through the model and advances its delay line.
  function automatic sample_t filter_sample(input sample_t x);
    longint acc;
    longint w;
    longint y;
    acc = longint'(x) <<< iirdf2_pkg::FRAC_BITS;
    for (int k = 1; k <= 3; k++) begin
      acc -= longint'(fb_coef[k]) * longint'(w_delay[k-1]);
    end
    w = round_frac(acc);
    // The intermediate value saturates before it feeds the output sum or
    // enters the delay line.
    if (w > STATE_HI) begin
      w = STATE_HI;
    end else if (w < STATE_LO) begin
      w = STATE_LO;
    end
    acc = longint'(ff_coef[0]) * w;
    for (int k = 1; k <= 3; k++) begin
      acc += longint'(ff_coef[k]) * longint'(w_delay[k-1]);
    end
    y = round_frac(acc);
    if (y > SAMPLE_HI) begin
      y = SAMPLE_HI;
    end else if (y < SAMPLE_LO) begin
      y = SAMPLE_LO;
    end
    w_delay[2] = w_delay[1];
    w_delay[1] = w_delay[0];
    w_delay[0] = w[iirdf2_pkg::STATE_W-1:0];
    return y[iirdf2_pkg::SAMPLE_W-1:0];
  endfunction

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output monitor. A beat moves when out_valid is high and our stall is
  // low at the same edge; both are read before this edge's updates land.
  // The stall for the next cycle is drawn after the check.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $display("%0t unexpected output beat: expected none, actual %0d",
                 $time, out_sample_out);
        errors++;
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (out_sample_out !== oldest_sample) begin
          $display("%0t sample_out mismatch: expected %0d, actual %0d",
                   $time, oldest_sample, out_sample_out);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offers one input beat, after a random gap, and holds it until it is
  // taken. Valid stays high on return so that a following beat can go
  // back to back; whoever idles next lowers it.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expected_samples.push_back(filter_sample(s));
  endtask

  // Stops sending until every predicted sample has come out. With nothing
  // outstanding the sender is already idle and valid is left alone.
  task automatic hold_until_drained();
    if (expected_samples.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_samples.size() != 0) begin
        @(posedge clk);
      end
    end
  endtask

  // Drains the filter and lets its program return to idle, so that the
  // coefficients may be changed.
  task automatic wait_for_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the enable is high for a single cycle, then lowered so
  // that two writes in a row never assign it twice in one step.
  task automatic cfg_write(input logic [iirdf2_pkg::CFG_IDX_W-1:0] idx,
                           input coef_t data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      iirdf2_pkg::REG_COEF_B0: ff_coef[0] = data;
      iirdf2_pkg::REG_COEF_B1: ff_coef[1] = data;
      iirdf2_pkg::REG_COEF_B2: ff_coef[2] = data;
      iirdf2_pkg::REG_COEF_B3: ff_coef[3] = data;
      iirdf2_pkg::REG_COEF_A1: fb_coef[1] = data;
      iirdf2_pkg::REG_COEF_A2: fb_coef[2] = data;
      iirdf2_pkg::REG_COEF_A3: fb_coef[3] = data;
      default: ;
    endcase
  endtask

  task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                            input coef_t b3, input coef_t a1, input coef_t a2,
                            input coef_t a3);
    cfg_write(iirdf2_pkg::REG_COEF_B0, b0);
    cfg_write(iirdf2_pkg::REG_COEF_B1, b1);
    cfg_write(iirdf2_pkg::REG_COEF_B2, b2);
    cfg_write(iirdf2_pkg::REG_COEF_B3, b3);
    cfg_write(iirdf2_pkg::REG_COEF_A1, a1);
    cfg_write(iirdf2_pkg::REG_COEF_A2, a2);
    cfg_write(iirdf2_pkg::REG_COEF_A3, a3);
  endtask

  function automatic coef_t extreme_coef();
    coef_t c;
    case ($urandom_range(4))
      0: c = COEF_MAX;
      1: c = COEF_MIN;
      2: c = COEF_UNITY;
      3: c = -COEF_UNITY;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Small feedback keeps the filter stable, so that outputs are not all
  // pinned to the rails.
  function automatic coef_t small_coef();
    int v;
    v = $urandom_range(2 * 32'h3000) - 32'h3000;
    return v[iirdf2_pkg::COEF_W-1:0];
  endfunction

  task automatic load_random_coefs();
    coef_t c [0:6];
    int style;
    style = $urandom_range(99);
    for (int i = 0; i < 7; i++) begin
      if (style < 25) begin
        c[i] = extreme_coef();
      end else if (style < 50 || i < 4) begin
        c[i] = coef_t'($urandom);
      end else begin
        c[i] = small_coef();
      end
    end
    load_coefs(c[0], c[1], c[2], c[3], c[4], c[5], c[6]);
    if ($urandom_range(9) == 0) begin
      cfg_write(REG_UNUSED, coef_t'($urandom));
    end
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: s = 16'sh7FFF;
        1: s = 16'sh8000;
        2: s = 16'sh0001;
        3: s = 16'shFFFF;
        default: s = '0;
      endcase
    end else if (pick < 40) begin
      s = sample_t'($urandom_range(512) - 256);
    end else begin
      s = sample_t'($urandom);
    end
    return s;
  endfunction

  // Straight after reset b0 is 1.0 and every other tap is zero, so each
  // output beat must equal its input, the extremes included.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    wait_for_idle();
  endtask

  // A write to the index past the last register must change nothing.
  task automatic test_unknown_index();
    cfg_write(REG_UNUSED, COEF_MAX);
    send_sample(16'sd1234);
    send_sample(-16'sd4321);
    send_sample(16'sh7FFF);
    wait_for_idle();
  endtask

  // An impulse through a setting where every tap, b1 and a1 among them,
  // has its own distinct weight.
  task automatic test_all_taps();
    load_coefs(20'sh08000, 20'sh04000, -20'sh02000, 20'sh01000,
               -20'sh08000, 20'sh02000, -20'sh01000);
    send_sample(16'sh7FFF);
    repeat (4) send_sample(16'sh0000);
    wait_for_idle();
  endtask

  // Feedback of almost -8 makes w swing between ever larger values of
  // alternating sign, so it saturates at both rails of its 32-bit range,
  // and the largest b0 drives the output into saturation both ways.
  task automatic test_saturation();
    load_coefs(COEF_MAX, COEF_MIN, 20'sd0, 20'sd0, COEF_MAX, 20'sd0, 20'sd0);
    repeat (5) send_sample(16'sh7FFF);
    repeat (5) send_sample(16'sh8000);
    wait_for_idle();
  endtask

  // Random traffic in blocks, each with a fresh coefficient setting.
  // Now and then the sender holds off until the filter has drained.
  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int n_items);
    int sent;
    int block_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      load_random_coefs();
      block_len = $urandom_range(160, 40);
      repeat (block_len) begin
        if ($urandom_range(99) < 2) begin
          hold_until_drained();
        end
        send_sample(random_sample());
      end
      sent += block_len;
      wait_for_idle();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_unknown_index();
    test_all_taps();
    test_saturation();
    test_random_phase(21, 51, 580);
    test_random_phase(51, 21, 580);
    test_random_phase(0, 0, 580);

    if (errors == 0 && expected_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> iir_direct_form_two.f
hw/rtl/iirdf2_pkg.sv
hw/rtl/iir_direct_form_two.sv
tb/testbench.sv
